[design/taie_pkg.sv]
// shared types and constants of the three-address instruction executor
package taie_pkg;

    localparam int OP_W      = 3;
    localparam int PC_W      = 10;
    localparam int IDX_W     = 6;
    localparam int CODE_W    = 4;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 11;
    localparam int ERR_W     = 2;
    localparam int DIV_STEPS = 32;

    typedef enum logic [OP_W-1:0] {
        OP_STORE_VAR = 3'd0,
        OP_LOAD_VAR  = 3'd1,
        OP_LOAD_IMM  = 3'd2,
        OP_LABEL     = 3'd3,
        OP_GOTO      = 3'd4,
        OP_IF        = 3'd5,
        OP_IFNOT     = 3'd6,
        OP_ALU       = 3'd7
    } t_op;

    typedef logic [CODE_W-1:0] t_alu_code;

    localparam t_alu_code ALU_ADD = 4'd0;
    localparam t_alu_code ALU_SUB = 4'd1;
    localparam t_alu_code ALU_MUL = 4'd2;
    localparam t_alu_code ALU_DIV = 4'd3;
    localparam t_alu_code ALU_MOD = 4'd4;
    localparam t_alu_code ALU_LT  = 4'd5;
    localparam t_alu_code ALU_GT  = 4'd6;
    localparam t_alu_code ALU_EQ  = 4'd7;
    localparam t_alu_code ALU_NE  = 4'd8;
    localparam t_alu_code ALU_LE  = 4'd9;
    localparam t_alu_code ALU_GE  = 4'd10;

    typedef logic [ERR_W-1:0] t_err;

    localparam t_err ERR_NONE     = 2'd0;
    localparam t_err ERR_DIV_ZERO = 2'd1;
    localparam t_err ERR_BAD_CODE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_NEGA,
        ST_NEGB,
        ST_DIVS,
        ST_FIXS,
        ST_WB
    } t_state;

endpackage

[design/taie_in_if.sv]
// instruction item channel
interface taie_in_if;
    logic                               valid;
    logic                               ready;
    logic [taie_pkg::OP_W-1:0]          op;
    logic [taie_pkg::PC_W-1:0]          instr_index;
    logic [taie_pkg::IDX_W-1:0]         dest_temp;
    logic [taie_pkg::IDX_W-1:0]         src_a_temp;
    logic [taie_pkg::IDX_W-1:0]         src_b_temp;
    logic [taie_pkg::CODE_W-1:0]        alu_code;
    logic [taie_pkg::IDX_W-1:0]         var_index;
    logic signed [taie_pkg::DATA_W-1:0] immediate;
    logic [taie_pkg::PC_W-1:0]          jump_target;

    modport source (
        output valid, op, instr_index, dest_temp, src_a_temp, src_b_temp,
               alu_code, var_index, immediate, jump_target,
        input  ready
    );
    modport sink (
        input  valid, op, instr_index, dest_temp, src_a_temp, src_b_temp,
               alu_code, var_index, immediate, jump_target,
        output ready
    );
endinterface

[design/taie_out_if.sv]
// result item channel
interface taie_out_if;
    logic                               valid;
    logic                               ready;
    logic [taie_pkg::LEN_W-1:0]         next_index;
    logic signed [taie_pkg::DATA_W-1:0] written_value;
    logic                               done_res;
    logic [taie_pkg::ERR_W-1:0]         error_code;

    modport source (
        output valid, next_index, written_value, done_res, error_code,
        input  ready
    );
    modport sink (
        input  valid, next_index, written_value, done_res, error_code,
        output ready
    );
endinterface

[design/taie_cfg_if.sv]
// configuration write channel
interface taie_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [taie_pkg::LEN_W-1:0] program_length;

    modport source (
        output valid, program_length,
        input  ready
    );
    modport sink (
        input  valid, program_length,
        output ready
    );
endinterface

[design/three_address_ir_executor_unit.sv]
// three-address instruction executor: temp and variable files, alu and sequencer
//
//  channel  | dir | payload                                           | accept
//  i_in     | in  | op, indices, alu_code, immediate, jump_target      | valid & ready
//  o_out    | out | next_index, written_value, done_res, error_code    | valid & ready
//  i_cfg    | in  | program_length                                    | valid & ready
//
// most items pass through accept with file read, execute and write back;
// divide and modulo add sign fixes and 32 restoring steps on the shared adder
// after reset a clearing pass writes zero to both files with i_in not ready;
// configuration writes are taken at any time
// a finished result waits in the output register; write back stalls until it is free
module three_address_ir_executor_unit #(
    parameter int TEMP_COUNT = 64,
    parameter int VAR_COUNT  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    taie_in_if.sink    i_in,
    taie_out_if.source o_out,
    taie_cfg_if.sink   i_cfg
);

    localparam int TA_W    = $clog2(TEMP_COUNT);
    localparam int VA_W    = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam int MAXC    = (TEMP_COUNT > VAR_COUNT) ? TEMP_COUNT : VAR_COUNT;
    localparam int CLR_W   = $clog2(MAXC);
    localparam int FIELD_N = 1 << taie_pkg::IDX_W;
    localparam int CNT_W   = $clog2(taie_pkg::DIV_STEPS);
    localparam int DW      = taie_pkg::DATA_W;
    localparam int LW      = taie_pkg::LEN_W;

    // index fields folded into the file depth
    logic [TA_W-1:0] tmod [FIELD_N];
    logic [VA_W-1:0] vmod [FIELD_N];

    for (genvar g = 0; g < FIELD_N; g++) begin : g_mod
        assign tmod[g] = TA_W'(g % TEMP_COUNT);
        assign vmod[g] = VA_W'(g % VAR_COUNT);
    end

    taie_pkg::t_state r_state, n_state;

    logic [LW-1:0]                r_prog_len;
    logic [CLR_W-1:0]             r_clr;
    taie_pkg::t_op                r_op;
    logic [taie_pkg::PC_W-1:0]    r_pc;
    logic [taie_pkg::PC_W-1:0]    r_tgt;
    taie_pkg::t_alu_code          r_code;
    logic [DW-1:0]                r_imm;
    logic [TA_W-1:0]              r_d;
    logic [VA_W-1:0]              r_vi;
    logic [DW-1:0]                r_rd_a, r_rd_b, r_rd_v;
    logic [DW-1:0]                r_a, r_b, r_rem;
    logic                         r_na, r_nb;
    logic [CNT_W-1:0]             r_cnt;
    logic [DW-1:0]                r_res;
    taie_pkg::t_err               r_err;
    logic [LW-1:0]                r_next;

    logic                         r_o_valid;
    logic [LW-1:0]                r_o_next;
    logic [DW-1:0]                r_o_value;
    logic                         r_o_done;
    taie_pkg::t_err               r_o_err;

    logic [DW-1:0] r_tmem [TEMP_COUNT];
    logic [DW-1:0] r_vmem [VAR_COUNT];

    logic            in_fire, cfg_fire, out_free, wb_fire;
    taie_pkg::t_op   in_op;
    logic [TA_W-1:0] ra_addr, rb_addr, t_waddr;
    logic [VA_W-1:0] v_raddr, v_waddr;
    logic            t_we, v_we;
    logic [DW-1:0]   mem_wdata;
    logic            clr_t, clr_v, clr_last, div_last;

    logic [DW+1:0]   add_x, add_y, add_s;
    logic            add_sub;
    logic [DW-1:0]   prod;
    logic            a_lt_b, a_eq_b, b_lt_a, is_divmod, b_zero;
    logic [DW-1:0]   alu_val, ex_val, rem_shift_lo, fix_src;
    logic [DW:0]     rem_shift;
    logic            fix_neg;
    taie_pkg::t_err  alu_err;
    logic [LW-1:0]   pc1, tgt11, ex_next;

    assign in_fire  = i_in.valid & i_in.ready;
    assign cfg_fire = i_cfg.valid & i_cfg.ready;
    assign out_free = !r_o_valid || o_out.ready;
    assign wb_fire  = (r_state == taie_pkg::ST_WB) && out_free;

    assign i_in.ready  = (r_state == taie_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_o_valid;
    assign o_out.next_index    = r_o_next;
    assign o_out.written_value = r_o_value;
    assign o_out.done_res      = r_o_done;
    assign o_out.error_code    = r_o_err;

    // file addressing
    assign in_op   = taie_pkg::t_op'(i_in.op);
    assign ra_addr = (in_op == taie_pkg::OP_ALU) ? tmod[i_in.src_a_temp] : tmod[i_in.dest_temp];
    assign rb_addr = tmod[i_in.src_b_temp];
    assign v_raddr = vmod[i_in.var_index];

    assign clr_t    = ({1'b0, r_clr} < (CLR_W+1)'(TEMP_COUNT));
    assign clr_v    = ({1'b0, r_clr} < (CLR_W+1)'(VAR_COUNT));
    assign clr_last = (r_clr == CLR_W'(MAXC - 1));
    assign div_last = (r_cnt == CNT_W'(taie_pkg::DIV_STEPS - 1));

    always_comb begin
        t_we      = 1'b0;
        v_we      = 1'b0;
        t_waddr   = r_d;
        v_waddr   = r_vi;
        mem_wdata = r_res;
        if (r_state == taie_pkg::ST_CLEAR) begin
            t_we      = clr_t;
            v_we      = clr_v;
            t_waddr   = r_clr[TA_W-1:0];
            v_waddr   = r_clr[VA_W-1:0];
            mem_wdata = '0;
        end else if (wb_fire) begin
            case (r_op) inside
                taie_pkg::OP_LOAD_VAR, taie_pkg::OP_LOAD_IMM, taie_pkg::OP_ALU: t_we = 1'b1;
                taie_pkg::OP_STORE_VAR:                                          v_we = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_waddr] <= mem_wdata;
        end
        if (v_we) begin
            r_vmem[v_waddr] <= mem_wdata;
        end
        if (in_fire) begin
            r_rd_a <= r_tmem[ra_addr];
            r_rd_b <= r_tmem[rb_addr];
            r_rd_v <= r_vmem[v_raddr];
        end
    end

    // shared adder: add, subtract, compare, negate and divide steps
    assign is_divmod    = (r_code == taie_pkg::ALU_DIV) || (r_code == taie_pkg::ALU_MOD);
    assign rem_shift    = {r_rem, r_a[DW-1]};
    assign rem_shift_lo = rem_shift[DW-1:0];
    assign fix_src      = (r_code == taie_pkg::ALU_DIV) ? r_a : r_rem;
    assign fix_neg      = (r_code == taie_pkg::ALU_DIV) ? (r_na ^ r_nb) : r_na;

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_state)
            taie_pkg::ST_EXEC: begin
                add_x   = {{2{r_rd_a[DW-1]}}, r_rd_a};
                add_y   = {{2{r_rd_b[DW-1]}}, r_rd_b};
                add_sub = (r_code != taie_pkg::ALU_ADD);
            end
            taie_pkg::ST_NEGA: begin
                add_y   = {2'b00, r_a};
                add_sub = 1'b1;
            end
            taie_pkg::ST_NEGB: begin
                add_y   = {2'b00, r_b};
                add_sub = 1'b1;
            end
            taie_pkg::ST_DIVS: begin
                add_x   = {1'b0, rem_shift};
                add_y   = {2'b00, r_b};
                add_sub = 1'b1;
            end
            taie_pkg::ST_FIXS: begin
                add_y   = {2'b00, fix_src};
                add_sub = 1'b1;
            end
            default: ;
        endcase
    end

    assign add_s = add_x + (add_sub ? ~add_y : add_y) + {{(DW+1){1'b0}}, add_sub};

    // only the low word of the product is kept
    assign prod   = r_rd_a * r_rd_b;
    assign a_lt_b = add_s[DW+1];
    assign a_eq_b = (r_rd_a == r_rd_b);
    assign b_lt_a = !a_lt_b && !a_eq_b;
    assign b_zero = (r_rd_b == '0);

    always_comb begin
        alu_val = '0;
        alu_err = taie_pkg::ERR_NONE;
        case (r_code)
            taie_pkg::ALU_ADD, taie_pkg::ALU_SUB: alu_val = add_s[DW-1:0];
            taie_pkg::ALU_MUL: alu_val = prod;
            taie_pkg::ALU_DIV, taie_pkg::ALU_MOD: begin
                if (b_zero) begin
                    alu_err = taie_pkg::ERR_DIV_ZERO;
                end
            end
            taie_pkg::ALU_LT: alu_val = DW'(a_lt_b);
            taie_pkg::ALU_GT: alu_val = DW'(b_lt_a);
            taie_pkg::ALU_EQ: alu_val = DW'(a_eq_b);
            taie_pkg::ALU_NE: alu_val = DW'(!a_eq_b);
            taie_pkg::ALU_LE: alu_val = DW'(!b_lt_a);
            taie_pkg::ALU_GE: alu_val = DW'(!a_lt_b);
            default: alu_err = taie_pkg::ERR_BAD_CODE;
        endcase
    end

    assign pc1   = LW'({1'b0, r_pc}) + LW'(1);
    assign tgt11 = LW'({1'b0, r_tgt});

    always_comb begin
        ex_val  = '0;
        ex_next = pc1;
        unique case (r_op)
            taie_pkg::OP_STORE_VAR: ex_val = r_rd_a;
            taie_pkg::OP_LOAD_VAR:  ex_val = r_rd_v;
            taie_pkg::OP_LOAD_IMM:  ex_val = r_imm;
            taie_pkg::OP_LABEL:     ;
            taie_pkg::OP_GOTO:      ex_next = tgt11;
            taie_pkg::OP_IF: begin
                ex_val = r_rd_a;
                if (r_rd_a != '0) begin
                    ex_next = tgt11;
                end
            end
            taie_pkg::OP_IFNOT: begin
                ex_val = r_rd_a;
                if (r_rd_a == '0) begin
                    ex_next = tgt11;
                end
            end
            taie_pkg::OP_ALU:       ex_val = alu_val;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= taie_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            taie_pkg::ST_CLEAR: if (clr_last) n_state = taie_pkg::ST_IDLE;
            taie_pkg::ST_IDLE:  if (in_fire) n_state = taie_pkg::ST_EXEC;
            taie_pkg::ST_EXEC: begin
                if ((r_op == taie_pkg::OP_ALU) && is_divmod && !b_zero) begin
                    n_state = taie_pkg::ST_NEGA;
                end else begin
                    n_state = taie_pkg::ST_WB;
                end
            end
            taie_pkg::ST_NEGA:  n_state = taie_pkg::ST_NEGB;
            taie_pkg::ST_NEGB:  n_state = taie_pkg::ST_DIVS;
            taie_pkg::ST_DIVS:  if (div_last) n_state = taie_pkg::ST_FIXS;
            taie_pkg::ST_FIXS:  n_state = taie_pkg::ST_WB;
            taie_pkg::ST_WB:    if (out_free) n_state = taie_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
            r_clr      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (cfg_fire) begin
                r_prog_len <= i_cfg.program_length;
            end
            if (r_state == taie_pkg::ST_CLEAR) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (wb_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= in_op;
            r_pc   <= i_in.instr_index;
            r_tgt  <= i_in.jump_target;
            r_code <= i_in.alu_code;
            r_imm  <= i_in.immediate;
            r_d    <= tmod[i_in.dest_temp];
            r_vi   <= vmod[i_in.var_index];
        end
        case (r_state)
            taie_pkg::ST_EXEC: begin
                r_res  <= ex_val;
                r_err  <= (r_op == taie_pkg::OP_ALU) ? alu_err : taie_pkg::ERR_NONE;
                r_next <= ex_next;
                r_a    <= r_rd_a;
                r_b    <= r_rd_b;
                r_na   <= r_rd_a[DW-1];
                r_nb   <= r_rd_b[DW-1];
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            taie_pkg::ST_NEGA: if (r_na) r_a <= add_s[DW-1:0];
            taie_pkg::ST_NEGB: if (r_nb) r_b <= add_s[DW-1:0];
            taie_pkg::ST_DIVS: begin
                // borrow out means the trial subtract failed
                r_rem <= add_s[DW+1] ? rem_shift_lo : add_s[DW-1:0];
                r_a   <= {r_a[DW-2:0], ~add_s[DW+1]};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            taie_pkg::ST_FIXS: r_res <= fix_neg ? add_s[DW-1:0] : fix_src;
            default: ;
        endcase
        if (wb_fire) begin
            r_o_next  <= r_next;
            r_o_value <= r_res;
            r_o_done  <= (r_next >= r_prog_len);
            r_o_err   <= r_err;
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_err != taie_pkg::ERR_NONE)) |-> (r_o_value == '0))
        else $error("error result carries a nonzero value");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_done == (r_o_next >= r_prog_len)))
        else $error("done flag disagrees with program length");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == taie_pkg::ST_EXEC))
        else $error("accepted item not executed next cycle");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == taie_pkg::ST_DIVS) && div_last) |=> (r_state == taie_pkg::ST_FIXS))
        else $error("divider did not finish after its last step");
`endif

endmodule

[tb/three_address_ir_executor_unit_tb.sv]
// testbench of the three-address instruction executor: predicts every result and checks it
module three_address_ir_executor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 170;
    localparam int PRINT_CAP      = 60;

    typedef struct {
        taie_pkg::t_op                      op;
        logic [taie_pkg::PC_W-1:0]          instr_index;
        logic [taie_pkg::IDX_W-1:0]         dest_temp;
        logic [taie_pkg::IDX_W-1:0]         src_a_temp;
        logic [taie_pkg::IDX_W-1:0]         src_b_temp;
        taie_pkg::t_alu_code                alu_code;
        logic [taie_pkg::IDX_W-1:0]         var_index;
        logic signed [taie_pkg::DATA_W-1:0] immediate;
        logic [taie_pkg::PC_W-1:0]          jump_target;
    } t_instr;

    typedef struct {
        logic [taie_pkg::LEN_W-1:0]         next_index;
        logic signed [taie_pkg::DATA_W-1:0] written_value;
        logic                               done_res;
        taie_pkg::t_err                     error_code;
    } t_result;

    // mirror of the temp and variable files, plus the queue of results still owed
    class t_ir_exec_scoreboard;
        logic [taie_pkg::DATA_W-1:0] temps [64];
        logic [taie_pkg::DATA_W-1:0] vars [64];
        logic [taie_pkg::LEN_W-1:0]  prog_len;
        t_result                     pending_results [$];
        int                          fails;

        function new();
            foreach (temps[k]) temps[k] = '0;
            foreach (vars[k]) vars[k] = '0;
            prog_len = '0;
            fails = 0;
        endfunction

        task report(string msg);
            if (fails < PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
            fails++;
        endtask

        function logic [taie_pkg::DATA_W-1:0] alu_eval(taie_pkg::t_alu_code code,
                                                       logic [taie_pkg::DATA_W-1:0] a,
                                                       logic [taie_pkg::DATA_W-1:0] b,
                                                       output taie_pkg::t_err err);
            logic                        na;
            logic                        nb;
            logic [taie_pkg::DATA_W-1:0] ma;
            logic [taie_pkg::DATA_W-1:0] mb;
            logic [taie_pkg::DATA_W-1:0] q;
            na = a[taie_pkg::DATA_W-1];
            nb = b[taie_pkg::DATA_W-1];
            ma = na ? (32'd0 - a) : a;
            mb = nb ? (32'd0 - b) : b;
            err = taie_pkg::ERR_NONE;
            case (code)
                taie_pkg::ALU_ADD: return a + b;
                taie_pkg::ALU_SUB: return a - b;
                taie_pkg::ALU_MUL: return a * b;
                taie_pkg::ALU_DIV: begin
                    if (b == 0) begin
                        err = taie_pkg::ERR_DIV_ZERO;
                        return '0;
                    end
                    q = ma / mb;
                    return (na != nb) ? (32'd0 - q) : q;
                end
                taie_pkg::ALU_MOD: begin
                    if (b == 0) begin
                        err = taie_pkg::ERR_DIV_ZERO;
                        return '0;
                    end
                    q = ma % mb;
                    return na ? (32'd0 - q) : q;
                end
                taie_pkg::ALU_LT: return ($signed(a) <  $signed(b)) ? 32'd1 : 32'd0;
                taie_pkg::ALU_GT: return ($signed(a) >  $signed(b)) ? 32'd1 : 32'd0;
                taie_pkg::ALU_EQ: return (a == b) ? 32'd1 : 32'd0;
                taie_pkg::ALU_NE: return (a != b) ? 32'd1 : 32'd0;
                taie_pkg::ALU_LE: return ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
                taie_pkg::ALU_GE: return ($signed(a) >= $signed(b)) ? 32'd1 : 32'd0;
                default: begin
                    err = taie_pkg::ERR_BAD_CODE;
                    return '0;
                end
            endcase
        endfunction

        function void note_instr(t_instr t);
            logic [taie_pkg::LEN_W-1:0]  nxt;
            logic [taie_pkg::DATA_W-1:0] val;
            taie_pkg::t_err              err;
            t_result                     r;
            nxt = {1'b0, t.instr_index} + 11'd1;
            val = '0;
            err = taie_pkg::ERR_NONE;
            case (t.op)
                taie_pkg::OP_STORE_VAR: begin
                    val = temps[t.dest_temp];
                    vars[t.var_index] = val;
                end
                taie_pkg::OP_LOAD_VAR: begin
                    val = vars[t.var_index];
                    temps[t.dest_temp] = val;
                end
                taie_pkg::OP_LOAD_IMM: begin
                    val = t.immediate;
                    temps[t.dest_temp] = val;
                end
                taie_pkg::OP_LABEL: ;
                taie_pkg::OP_GOTO: nxt = {1'b0, t.jump_target};
                taie_pkg::OP_IF: begin
                    val = temps[t.dest_temp];
                    if (val != 0) nxt = {1'b0, t.jump_target};
                end
                taie_pkg::OP_IFNOT: begin
                    val = temps[t.dest_temp];
                    if (val == 0) nxt = {1'b0, t.jump_target};
                end
                default: begin
                    val = alu_eval(t.alu_code, temps[t.src_a_temp], temps[t.src_b_temp], err);
                    temps[t.dest_temp] = val;
                end
            endcase
            r.next_index = nxt;
            r.written_value = val;
            r.done_res = (nxt >= prog_len);
            r.error_code = err;
            pending_results.push_back(r);
        endfunction

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("result item arrived with none pending");
                return;
            end
            want = pending_results.pop_front();
            if (got.next_index !== want.next_index)
                report($sformatf("next_index %0d, predicted %0d",
                                 got.next_index, want.next_index));
            if (got.written_value !== want.written_value)
                report($sformatf("written_value %0d, predicted %0d",
                                 got.written_value, want.written_value));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %0b, predicted %0b", got.done_res, want.done_res));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, predicted %0d",
                                 got.error_code, want.error_code));
        endtask
    endclass

    logic clk;
    logic rst_n;

    taie_in_if  in_ch ();
    taie_out_if out_ch ();
    taie_cfg_if cfg_ch ();

    t_ir_exec_scoreboard exec_sb;

    int rx_hold_req;
    int rx_stall_pct;
    int tx_gap_pct;

    three_address_ir_executor_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_instr make_instr(taie_pkg::t_op op, int d, int a, int b,
                                          taie_pkg::t_alu_code code,
                                          int v, int imm, int tgt, int pc);
        t_instr t;
        t.op = op;
        t.instr_index = taie_pkg::PC_W'(pc);
        t.dest_temp = taie_pkg::IDX_W'(d);
        t.src_a_temp = taie_pkg::IDX_W'(a);
        t.src_b_temp = taie_pkg::IDX_W'(b);
        t.alu_code = code;
        t.var_index = taie_pkg::IDX_W'(v);
        t.immediate = imm;
        t.jump_target = taie_pkg::PC_W'(tgt);
        return t;
    endfunction

    function automatic t_instr random_instr(int len);
        t_instr t;
        int     pick;
        bit     narrow;
        narrow = ($urandom_range(0, 3) != 0);
        // a narrow set of temps keeps read-after-write hazards frequent
        t.dest_temp  = narrow ? taie_pkg::IDX_W'($urandom_range(0, 7))
                              : taie_pkg::IDX_W'($urandom);
        t.src_a_temp = narrow ? taie_pkg::IDX_W'($urandom_range(0, 7))
                              : taie_pkg::IDX_W'($urandom);
        t.src_b_temp = narrow ? taie_pkg::IDX_W'($urandom_range(0, 7))
                              : taie_pkg::IDX_W'($urandom);
        t.var_index  = narrow ? taie_pkg::IDX_W'($urandom_range(0, 7))
                              : taie_pkg::IDX_W'($urandom);
        t.alu_code = ($urandom_range(0, 11) == 0)
                   ? taie_pkg::t_alu_code'($urandom_range(11, 15))
                   : taie_pkg::t_alu_code'($urandom_range(0, 10));
        case ($urandom_range(0, 3))
            0: case ($urandom_range(0, 4))
                0: t.immediate = 32'sh8000_0000;
                1: t.immediate = 32'sh7fff_ffff;
                2: t.immediate = -1;
                3: t.immediate = 0;
                default: t.immediate = 1;
            endcase
            1: t.immediate = $urandom_range(0, 20) - 10;
            default: t.immediate = $urandom;
        endcase
        // land on the done boundary now and then
        t.instr_index = ($urandom_range(0, 5) == 0)
                      ? taie_pkg::PC_W'(len - $urandom_range(0, 1))
                      : taie_pkg::PC_W'($urandom);
        t.jump_target = ($urandom_range(0, 5) == 0)
                      ? taie_pkg::PC_W'(len - $urandom_range(0, 1))
                      : taie_pkg::PC_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)      t.op = taie_pkg::OP_LOAD_IMM;
        else if (pick < 55) t.op = taie_pkg::OP_ALU;
        else if (pick < 65) t.op = taie_pkg::OP_STORE_VAR;
        else if (pick < 73) t.op = taie_pkg::OP_LOAD_VAR;
        else if (pick < 79) t.op = taie_pkg::OP_LABEL;
        else if (pick < 85) t.op = taie_pkg::OP_GOTO;
        else if (pick < 93) t.op = taie_pkg::OP_IF;
        else                t.op = taie_pkg::OP_IFNOT;
        return t;
    endfunction

    // valid stays high across back-to-back items; it drops only for a gap
    task send_instr(t_instr t, int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= t.op;
        in_ch.instr_index <= t.instr_index;
        in_ch.dest_temp   <= t.dest_temp;
        in_ch.src_a_temp  <= t.src_a_temp;
        in_ch.src_b_temp  <= t.src_b_temp;
        in_ch.alu_code    <= t.alu_code;
        in_ch.var_index   <= t.var_index;
        in_ch.immediate   <= t.immediate;
        in_ch.jump_target <= t.jump_target;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task write_length(int len);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.program_length <= taie_pkg::LEN_W'(len);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait on the clock first so the monitor has noted the item just accepted
    task wait_drain(int tail);
        @(posedge clk);
        while (exec_sb.pending_results.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    always @(posedge clk) begin : monitor
        t_instr  seen;
        t_result got;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                exec_sb.prog_len = cfg_ch.program_length;
            if (in_ch.valid && in_ch.ready) begin
                seen.op          = taie_pkg::t_op'(in_ch.op);
                seen.instr_index = in_ch.instr_index;
                seen.dest_temp   = in_ch.dest_temp;
                seen.src_a_temp  = in_ch.src_a_temp;
                seen.src_b_temp  = in_ch.src_b_temp;
                seen.alu_code    = in_ch.alu_code;
                seen.var_index   = in_ch.var_index;
                seen.immediate   = in_ch.immediate;
                seen.jump_target = in_ch.jump_target;
                exec_sb.note_instr(seen);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.next_index    = out_ch.next_index;
                got.written_value = out_ch.written_value;
                got.done_res      = out_ch.done_res;
                got.error_code    = out_ch.error_code;
                exec_sb.check_result(got);
            end
        end
    end

    initial begin : rx_side
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen = 0;
        hold_left = 0;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req != hold_seen) begin
                hold_seen = rx_hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap(rx_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        int     phase_len [5];
        int     phase_rx [5];
        int     phase_tx [5];
        int     pc;
        t_instr t;
        exec_sb = new();
        rx_hold_req  <= 0;
        rx_stall_pct <= 0;
        tx_gap_pct   <= 0;
        rst_n        <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= taie_pkg::OP_LABEL;
        in_ch.instr_index <= '0;
        in_ch.dest_temp   <= '0;
        in_ch.src_a_temp  <= '0;
        in_ch.src_b_temp  <= '0;
        in_ch.alu_code    <= taie_pkg::ALU_ADD;
        in_ch.var_index   <= '0;
        in_ch.immediate   <= '0;
        in_ch.jump_target <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.program_length <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the largest program length
        write_length(1024);
        pc = 0;
        send_instr(make_instr(taie_pkg::OP_LOAD_IMM, 0, 0, 0, taie_pkg::ALU_ADD, 0,
                              32'sh7fff_ffff, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_LOAD_IMM, 1, 0, 0, taie_pkg::ALU_ADD, 0,
                              32'sh8000_0000, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_LOAD_IMM, 2, 0, 0, taie_pkg::ALU_ADD, 0,
                              -1, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_LOAD_IMM, 63, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_ALU, 3, 0, 0, taie_pkg::ALU_ADD, 0, 0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_ALU, 4, 1, 0, taie_pkg::ALU_SUB, 0, 0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_ALU, 5, 0, 2, taie_pkg::ALU_MUL, 0, 0, 0, pc++), 0);
        // most negative over minus one
        send_instr(make_instr(taie_pkg::OP_ALU, 6, 1, 2, taie_pkg::ALU_DIV, 0, 0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_ALU, 7, 1, 2, taie_pkg::ALU_MOD, 0, 0, 0, pc++), 0);
        // zero divisor
        send_instr(make_instr(taie_pkg::OP_ALU, 8, 0, 63, taie_pkg::ALU_DIV, 0, 0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_ALU, 9, 1, 63, taie_pkg::ALU_MOD, 0, 0, 0, pc++), 0);
        for (int c = taie_pkg::ALU_LT; c <= taie_pkg::ALU_GE; c++)
            send_instr(make_instr(taie_pkg::OP_ALU, 10, 1, 0, taie_pkg::t_alu_code'(c),
                                  0, 0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_ALU, 11, 0, 1, taie_pkg::t_alu_code'(15),
                              0, 0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_STORE_VAR, 1, 0, 0, taie_pkg::ALU_ADD, 63,
                              0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_LOAD_VAR, 12, 0, 0, taie_pkg::ALU_ADD, 63,
                              0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_LOAD_VAR, 13, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_LABEL, 0, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 0, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_GOTO, 0, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 1023, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_IF, 0, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 500, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_IF, 63, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 500, pc++), 0);
        send_instr(make_instr(taie_pkg::OP_IFNOT, 63, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 0, pc++), 0);
        // last index, so the following one reaches the length
        send_instr(make_instr(taie_pkg::OP_IFNOT, 0, 0, 0, taie_pkg::ALU_ADD, 0,
                              0, 7, 1023), 0);
        in_ch.valid <= 1'b0;
        wait_drain(8);

        phase_len = '{0, 1024, $urandom_range(2, 1023), 1, 512};
        phase_rx  = '{0, 30, 10, 60, 25};
        phase_tx  = '{0, 30, 0, 10, 25};
        for (int p = 0; p < 5; p++) begin
            write_length(phase_len[p]);
            rx_stall_pct <= phase_rx[p];
            tx_gap_pct   <= phase_tx[p];
            // long receiver hold-off while the sender keeps offering
            if (p == 2) rx_hold_req <= rx_hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender pauses until every owed result is back
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    in_ch.valid <= 1'b0;
                    wait_drain(1);
                end
                t = random_instr(phase_len[p]);
                send_instr(t, pick_gap(tx_gap_pct));
            end
            in_ch.valid <= 1'b0;
            wait_drain(8);
        end

        wait_drain(40);
        if (exec_sb.pending_results.size() != 0)
            exec_sb.report("results still owed at end of run");
        if (exec_sb.fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
